// ===== hw/rtl/kick_drum_voice_synth_core_macros.svh =====
// Assertion macros shared by the kick drum voice RTL.
`ifndef KICK_DRUM_VOICE_SYNTH_CORE_MACROS_SVH
`define KICK_DRUM_VOICE_SYNTH_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KDVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KDVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kdvs_pkg.sv =====
// Package for the kick drum voice: types, constants and the quarter-wave sine table.
package kdvs_pkg;

  // Widths and default parameter values.
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int PHASE_WIDTH_DEF = 32;
  localparam int SINE_DEPTH      = 1024;
  localparam int SINE_IDX_W      = $clog2(SINE_DEPTH);
  localparam int Q23_W           = 24;
  localparam int ACC_W           = 64;

  // Fixed-point constants.
  localparam logic [Q23_W-1:0] Q23_ONE      = 24'd8388608;
  localparam logic [Q23_W-1:0] CLICK_OFFSET = 24'd4194304;
  localparam logic [24:0]      POS_LIMIT    = 25'd8388607;
  localparam logic [24:0]      NEG_LIMIT    = 25'd8388608;

  // Register reset values.
  localparam logic [15:0] ATTACK_LEN_RST  = 16'd48;
  localparam logic [17:0] DECAY_LEN_RST   = 18'd7200;
  localparam logic [9:0]  CLICK_LEN_RST   = 10'd24;
  localparam logic [23:0] ATTACK_STEP_RST = 24'd174763;
  localparam logic [23:0] DECAY_STEP_RST  = 24'd1165;
  localparam logic [31:0] START_STEP_RST  = 32'd26843546;
  localparam logic [31:0] BASE_STEP_RST   = 32'd3579139;
  localparam logic [16:0] LEVEL_RST       = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ATTACK_LEN  = 3'd0,
    CFG_DECAY_LEN   = 3'd1,
    CFG_CLICK_LEN   = 3'd2,
    CFG_ATTACK_STEP = 3'd3,
    CFG_DECAY_STEP  = 3'd4,
    CFG_START_STEP  = 3'd5,
    CFG_BASE_STEP   = 3'd6,
    CFG_LEVEL       = 3'd7
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV,
    S_SINE,
    S_MUL_START,
    S_MUL_BASE,
    S_PHASE,
    S_MUL_AMP,
    S_MUL_LVL_LO,
    S_MUL_LVL_HI,
    S_ROUND
  } state_t;

  typedef logic [Q23_W-1:0] sine_rom_t [SINE_DEPTH];

  // One table entry: sin(pi/2 * (2k+1) / (2 * depth)) in Q1.23, by a Horner series in Q30.
  // The depth is a power of two, so dividing by twice the depth is a right shift.
  function automatic logic [Q23_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'd1686629713 * (64'(k) * 64'd2 + 64'd1)) >> (SINE_IDX_W + 1);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 64'd110;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + 64'd64) >> 7;
    return (s > 64'(Q23_ONE)) ? Q23_ONE : s[Q23_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  // Quarter-wave sine table, fixed at elaboration.
  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== hw/rtl/kick_drum_voice_synth_core.sv =====
// Kick drum voice: envelopes, pitch glide, table sine and output scaling on a shared multiplier.
// Each request is one audio tick and yields one signed 24-bit sample. A request is taken
// only while the voice is idle; it then passes through the envelopes and table read,
// the sine sign and click, five passes of the shared 32x24 multiply-accumulate unit, a
// phase update and a rounding step before the result reaches the output register, and the
// voice takes no new request until that rounding step is done. A new request may be taken
// while the previous result still waits in the output register; the final step waits only
// if that register is still full. Configuration writes are accepted in every cycle and
// must only be issued while the voice is idle. No clearing pass follows reset.
`include "kick_drum_voice_synth_core_macros.svh"

module kick_drum_voice_synth_core #(
  parameter int COUNT_WIDTH = kdvs_pkg::COUNT_WIDTH_DEF,
  parameter int PHASE_WIDTH = kdvs_pkg::PHASE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Tick requests.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_trigger,
  // Samples.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_sample,
  output logic               out_clipped,
  // Register writes.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QB    = PHASE_WIDTH - 2;
  localparam int IW    = kdvs_pkg::SINE_IDX_W;
  localparam int IPW   = QB + IW + 1;
  localparam int CMP_W = (COUNT_WIDTH > 18) ? COUNT_WIDTH : 18;
  localparam int QW    = kdvs_pkg::Q23_W;
  localparam int AW    = kdvs_pkg::ACC_W;

  // Configuration registers.
  logic [15:0] attack_len_r;
  logic [17:0] decay_len_r;
  logic [9:0]  click_len_r;
  logic [23:0] attack_step_r;
  logic [23:0] decay_step_r;
  logic [31:0] start_step_r;
  logic [31:0] base_step_r;
  logic [16:0] level_r;

  // Voice state.
  kdvs_pkg::state_t       state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [QW-1:0]          amp_r, amp_nxt;
  logic [QW-1:0]          pe_r, pe_nxt;
  logic [PHASE_WIDTH-1:0] phase_r, phase_nxt;

  // Working registers of one request.
  logic [QW-1:0]          rom_q_r, rom_q_nxt;
  logic                   quad_neg_r, quad_neg_nxt;
  logic                   click_r, click_nxt;
  logic [QW-1:0]          mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [QW-1:0]          hold_r, hold_nxt;
  logic [AW-1:0]          acc_r, acc_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic signed [23:0]     out_sample_r, out_sample_nxt;
  logic                   out_clipped_r, out_clipped_nxt;

  // Shared multiplier controls.
  logic [31:0]            mul_a;
  logic [QW-1:0]          mul_b;
  logic                   mul_shift;
  logic                   mul_clear;
  logic                   mul_en;
  logic [55:0]            mul_p;
  logic [AW-1:0]          mul_sh;

  // Helper values.
  logic [1:0]             quad;
  logic [QB-1:0]          frac;
  logic [IPW-1:0]         idx_prod;
  logic [IW:0]            idx_raw;
  logic [IW-1:0]          idx_clamp;
  logic [IW-1:0]          rom_idx;
  logic [QW:0]            amp_sum;
  logic [QW:0]            pe_sum;
  logic                   in_attack, in_decay, in_click;
  logic signed [25:0]     sv;
  logic signed [25:0]     v;
  logic [31:0]            inc32;
  logic [PHASE_WIDTH+31:0] inc_ext;
  logic [PHASE_WIDTH-1:0] inc_p;
  logic [AW-1:0]          rnd;
  logic [24:0]            rmag;
  logic                   can_write;

  assign in_ready    = (state_r == kdvs_pkg::S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  // Table index from the phase: quadrant, scaled fraction, mirror in odd quadrants.
  assign quad      = phase_r[PHASE_WIDTH-1:PHASE_WIDTH-2];
  assign frac      = phase_r[QB-1:0];
  assign idx_prod  = IPW'(frac) * IPW'(kdvs_pkg::SINE_DEPTH);
  assign idx_raw   = idx_prod[IPW-1:QB];
  assign idx_clamp = (idx_raw >= (IW+1)'(kdvs_pkg::SINE_DEPTH)) ?
                     IW'(kdvs_pkg::SINE_DEPTH - 1) : idx_raw[IW-1:0];
  assign rom_idx   = quad[0] ? (IW'(kdvs_pkg::SINE_DEPTH - 1) - idx_clamp) : idx_clamp;

  // Envelope windows for the current tick count.
  assign in_attack = CMP_W'(tick_r) < CMP_W'(attack_len_r);
  assign in_decay  = CMP_W'(tick_r) < CMP_W'(decay_len_r);
  assign in_click  = CMP_W'(tick_r) < CMP_W'(click_len_r);
  assign amp_sum   = {1'b0, amp_r} + {1'b0, attack_step_r};
  assign pe_sum    = {1'b0, pe_r} + {1'b0, decay_step_r};

  // Signed sine plus click offset.
  assign sv = quad_neg_r ? -$signed({2'b00, rom_q_r}) : $signed({2'b00, rom_q_r});
  assign v  = sv + (click_r ? $signed({2'b00, kdvs_pkg::CLICK_OFFSET}) : 26'sd0);

  // Phase increment scaled from 32-bit turns to the phase width.
  assign inc32   = acc_r[54:23];
  assign inc_ext = {inc32, {PHASE_WIDTH{1'b0}}};
  assign inc_p   = inc_ext[PHASE_WIDTH+31 -: PHASE_WIDTH];

  // Round half up on the magnitude.
  assign rnd  = acc_r + (AW'(1) << 38);
  assign rmag = rnd[63:39];

  // Shared multiply-accumulate unit.
  assign mul_p  = 56'(mul_a) * 56'(mul_b);
  assign mul_sh = mul_shift ? {mul_p[39:0], 24'b0} : {8'b0, mul_p};

  assign can_write = !out_valid_r || out_ready;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt       = state_r;
    tick_nxt        = tick_r;
    amp_nxt         = amp_r;
    pe_nxt          = pe_r;
    phase_nxt       = phase_r;
    rom_q_nxt       = rom_q_r;
    quad_neg_nxt    = quad_neg_r;
    click_nxt       = click_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    hold_nxt        = hold_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_sample_nxt  = out_sample_r;
    out_clipped_nxt = out_clipped_r;
    mul_a           = start_step_r;
    mul_b           = kdvs_pkg::Q23_ONE - pe_r;
    mul_shift       = 1'b0;
    mul_clear       = 1'b1;
    mul_en          = 1'b0;

    unique case (state_r)
      kdvs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_trigger) begin
            tick_nxt  = '0;
            amp_nxt   = '0;
            pe_nxt    = '0;
            phase_nxt = '0;
          end
          state_nxt = kdvs_pkg::S_ENV;
        end
      end
      kdvs_pkg::S_ENV: begin
        if (in_attack) begin
          amp_nxt = (amp_sum > {1'b0, kdvs_pkg::Q23_ONE}) ? kdvs_pkg::Q23_ONE : amp_sum[QW-1:0];
        end else begin
          amp_nxt = (amp_r > decay_step_r) ? (amp_r - decay_step_r) : '0;
        end
        if (in_decay) begin
          pe_nxt = (pe_sum > {1'b0, kdvs_pkg::Q23_ONE}) ? kdvs_pkg::Q23_ONE : pe_sum[QW-1:0];
        end
        rom_q_nxt    = kdvs_pkg::SINE_ROM[rom_idx];
        quad_neg_nxt = quad[1];
        click_nxt    = in_click;
        if (tick_r != '1) begin
          tick_nxt = tick_r + COUNT_WIDTH'(1);
        end
        state_nxt = kdvs_pkg::S_SINE;
      end
      kdvs_pkg::S_SINE: begin
        neg_nxt   = v[25];
        mag_nxt   = v[25] ? QW'(-v) : QW'(v);
        state_nxt = kdvs_pkg::S_MUL_START;
      end
      kdvs_pkg::S_MUL_START: begin
        mul_en    = 1'b1;
        state_nxt = kdvs_pkg::S_MUL_BASE;
      end
      kdvs_pkg::S_MUL_BASE: begin
        mul_a     = base_step_r;
        mul_b     = pe_r;
        mul_clear = 1'b0;
        mul_en    = 1'b1;
        state_nxt = kdvs_pkg::S_PHASE;
      end
      kdvs_pkg::S_PHASE: begin
        phase_nxt = phase_r + inc_p;
        state_nxt = kdvs_pkg::S_MUL_AMP;
      end
      kdvs_pkg::S_MUL_AMP: begin
        mul_a     = 32'(mag_r);
        mul_b     = amp_r;
        mul_en    = 1'b1;
        state_nxt = kdvs_pkg::S_MUL_LVL_LO;
      end
      kdvs_pkg::S_MUL_LVL_LO: begin
        mul_a     = 32'(level_r);
        mul_b     = acc_r[23:0];
        hold_nxt  = acc_r[47:24];
        mul_en    = 1'b1;
        state_nxt = kdvs_pkg::S_MUL_LVL_HI;
      end
      kdvs_pkg::S_MUL_LVL_HI: begin
        mul_a     = 32'(level_r);
        mul_b     = hold_r;
        mul_shift = 1'b1;
        mul_clear = 1'b0;
        mul_en    = 1'b1;
        state_nxt = kdvs_pkg::S_ROUND;
      end
      kdvs_pkg::S_ROUND: begin
        // Saturate, apply the sign and load the output register once it is free.
        if (can_write) begin
          out_valid_nxt = 1'b1;
          if (!neg_r) begin
            out_clipped_nxt = rmag > kdvs_pkg::POS_LIMIT;
            out_sample_nxt  = (rmag > kdvs_pkg::POS_LIMIT) ?
                              24'sd8388607 : $signed(rmag[23:0]);
          end else begin
            out_clipped_nxt = rmag > kdvs_pkg::NEG_LIMIT;
            out_sample_nxt  = (rmag > kdvs_pkg::NEG_LIMIT) ?
                              -24'sd8388608 : $signed(24'(-rmag));
          end
          state_nxt = kdvs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kdvs_pkg::S_IDLE;
      end
    endcase

    acc_nxt = mul_en ? ((mul_clear ? AW'(0) : acc_r) + mul_sh) : acc_r;
  end

  // State register and voice state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kdvs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= '1;
      amp_r       <= '0;
      pe_r        <= '0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      amp_r       <= amp_nxt;
      pe_r        <= pe_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk) begin
    rom_q_r       <= rom_q_nxt;
    quad_neg_r    <= quad_neg_nxt;
    click_r       <= click_nxt;
    mag_r         <= mag_nxt;
    neg_r         <= neg_nxt;
    hold_r        <= hold_nxt;
    acc_r         <= acc_nxt;
    out_sample_r  <= out_sample_nxt;
    out_clipped_r <= out_clipped_nxt;
  end

  // Configuration register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r  <= kdvs_pkg::ATTACK_LEN_RST;
      decay_len_r   <= kdvs_pkg::DECAY_LEN_RST;
      click_len_r   <= kdvs_pkg::CLICK_LEN_RST;
      attack_step_r <= kdvs_pkg::ATTACK_STEP_RST;
      decay_step_r  <= kdvs_pkg::DECAY_STEP_RST;
      start_step_r  <= kdvs_pkg::START_STEP_RST;
      base_step_r   <= kdvs_pkg::BASE_STEP_RST;
      level_r       <= kdvs_pkg::LEVEL_RST;
    end else if (cfg_valid) begin
      unique case (kdvs_pkg::cfg_idx_t'(cfg_index))
        kdvs_pkg::CFG_ATTACK_LEN:  attack_len_r  <= cfg_data[15:0];
        kdvs_pkg::CFG_DECAY_LEN:   decay_len_r   <= cfg_data[17:0];
        kdvs_pkg::CFG_CLICK_LEN:   click_len_r   <= cfg_data[9:0];
        kdvs_pkg::CFG_ATTACK_STEP: attack_step_r <= cfg_data[23:0];
        kdvs_pkg::CFG_DECAY_STEP:  decay_step_r  <= cfg_data[23:0];
        kdvs_pkg::CFG_START_STEP:  start_step_r  <= cfg_data;
        kdvs_pkg::CFG_BASE_STEP:   base_step_r   <= cfg_data;
        kdvs_pkg::CFG_LEVEL:       level_r       <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Checks on the envelopes, the restart and the saturation.
  `KDVS_ASSERT_NOW(a_amp_bounded, 1'b1, amp_r <= kdvs_pkg::Q23_ONE, "amplitude above one")
  `KDVS_ASSERT_NOW(a_pe_bounded, 1'b1, pe_r <= kdvs_pkg::Q23_ONE, "pitch envelope above one")
  `KDVS_ASSERT_NEXT(a_restart, in_valid && in_ready && in_trigger, tick_r == '0 && amp_r == '0 && phase_r == '0, "trigger did not restart the voice")
  `KDVS_ASSERT_NOW(a_clip_extreme, out_valid_r && out_clipped_r, out_sample_r == 24'sd8388607 || out_sample_r == -24'sd8388608, "clipped sample not at full scale")

endmodule
